### rtl/core/acdc_pkg.sv
// ----------------------------------------------------------------------------
// acdc_pkg
// Types, constants and lookup functions for the actuator command to DAC
// code converter.
// ----------------------------------------------------------------------------
package acdc_pkg;

  localparam int CMD_W     = 14;
  localparam int CODE_W    = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 2;

  localparam int NUM_W  = 17;
  localparam int Q_W    = 12;
  localparam int LVL_W  = 11;
  localparam int QUO_W  = 8;
  localparam int KMUL_W = 26;
  localparam int PROD_W = LVL_W + KMUL_W;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_SINGLE = 2'd0;
  localparam mode_t MODE_SPLIT  = 2'd1;
  localparam mode_t MODE_PUMP   = 2'd2;

  localparam logic KIND_CURRENT = 1'b0;
  localparam logic KIND_VOLTAGE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KIND = 2'd1;

  localparam logic [CMD_W-1:0] CMD_MAX  = 14'd10000;
  localparam logic [CMD_W-1:0] CMD_HALF = 14'd5000;

  // x / 25 as (x * DIV25_K) >> DIV25_S, exact for x below 2^17
  localparam logic [17:0] DIV25_K = 18'd167773;
  localparam int          DIV25_S = 22;
  // m / 10 as (m * DIV10_K) >> DIV10_S, exact for m below 2^11
  localparam logic [KMUL_W-1:0] DIV10_K = 26'd1639;
  localparam int                DIV10_S = 14;
  // floor(v * 32768 / 10000) as (v * VOLT_K) >> VOLT_S
  localparam logic [KMUL_W-1:0] VOLT_K = 26'd54975582;
  localparam int                VOLT_S = 24;

  localparam logic [Q_W-1:0]   BASE_MA    = 12'd400;
  localparam logic [Q_W-1:0]   FULL_MA    = 12'd2000;
  localparam logic [Q_W-1:0]   FULL_V     = 12'd1000;
  localparam logic [LVL_W-1:0] MA_LOW     = 11'd390;
  localparam logic [LVL_W-1:0] MA_HIGH    = 11'd2010;
  localparam logic [QUO_W-1:0] IDX_BASE   = 8'd39;
  localparam logic [CODE_W-1:0] V_CODE_MAX = 12'd3278;

  localparam int CAL_LEN = 163;
  localparam logic [QUO_W-1:0] CAL_LAST = 8'(CAL_LEN - 1);

  localparam logic [CODE_W-1:0] CAL_ROM [CAL_LEN] = '{
    12'd632,  12'd632,  12'd665,  12'd681,  12'd698,  12'd714,  12'd730,  12'd747,
    12'd763,  12'd780,  12'd797,  12'd813,  12'd830,  12'd846,  12'd863,  12'd879,
    12'd896,  12'd913,  12'd929,  12'd946,  12'd962,  12'd979,  12'd995,  12'd1012,
    12'd1029, 12'd1045, 12'd1062, 12'd1078, 12'd1095, 12'd1112, 12'd1128, 12'd1144,
    12'd1161, 12'd1178, 12'd1194, 12'd1211, 12'd1227, 12'd1243, 12'd1260, 12'd1277,
    12'd1294, 12'd1311, 12'd1328, 12'd1343, 12'd1359, 12'd1376, 12'd1393, 12'd1410,
    12'd1426, 12'd1442, 12'd1459, 12'd1476, 12'd1492, 12'd1508, 12'd1525, 12'd1542,
    12'd1559, 12'd1575, 12'd1592, 12'd1608, 12'd1625, 12'd1641, 12'd1658, 12'd1674,
    12'd1691, 12'd1707, 12'd1724, 12'd1740, 12'd1757, 12'd1774, 12'd1790, 12'd1808,
    12'd1824, 12'd1840, 12'd1856, 12'd1873, 12'd1890, 12'd1906, 12'd1923, 12'd1939,
    12'd1956, 12'd1972, 12'd1989, 12'd2006, 12'd2022, 12'd2039, 12'd2056, 12'd2072,
    12'd2089, 12'd2105, 12'd2122, 12'd2138, 12'd2155, 12'd2171, 12'd2188, 12'd2205,
    12'd2221, 12'd2238, 12'd2254, 12'd2271, 12'd2287, 12'd2304, 12'd2321, 12'd2338,
    12'd2354, 12'd2371, 12'd2387, 12'd2404, 12'd2420, 12'd2437, 12'd2453, 12'd2470,
    12'd2487, 12'd2503, 12'd2520, 12'd2536, 12'd2553, 12'd2570, 12'd2587, 12'd2603,
    12'd2620, 12'd2636, 12'd2653, 12'd2670, 12'd2686, 12'd2703, 12'd2719, 12'd2736,
    12'd2752, 12'd2769, 12'd2786, 12'd2802, 12'd2820, 12'd2836, 12'd2853, 12'd2869,
    12'd2886, 12'd2902, 12'd2919, 12'd2935, 12'd2952, 12'd2968, 12'd2985, 12'd3002,
    12'd3018, 12'd3035, 12'd3051, 12'd3068, 12'd3085, 12'd3102, 12'd3118, 12'd3135,
    12'd3151, 12'd3168, 12'd3184, 12'd3201, 12'd3218, 12'd3234, 12'd3251, 12'd3267,
    12'd3284, 12'd3315, 12'd3317
  };

  typedef struct packed {
    logic add_base;
    logic clamp;
    logic full1;
    logic full2;
    logic current;
    logic zero;
  } ctl_t;

  // floor(r * 1.6) for a remainder digit
  function automatic logic [3:0] frac_step(input logic [3:0] r);
    logic [3:0] s;
    case (r)
      4'd0:    s = 4'd0;
      4'd1:    s = 4'd1;
      4'd2:    s = 4'd3;
      4'd3:    s = 4'd4;
      4'd4:    s = 4'd6;
      4'd5:    s = 4'd8;
      4'd6:    s = 4'd9;
      4'd7:    s = 4'd11;
      4'd8:    s = 4'd12;
      4'd9:    s = 4'd14;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [4:0] band_offset(input logic [QUO_W-1:0] b);
    logic [4:0] off;
    if (b <= 8'd60) begin
      off = 5'd4;
    end else if (b <= 8'd110) begin
      off = 5'd7;
    end else if (b <= 8'd140) begin
      off = 5'd9;
    end else if (b <= 8'd170) begin
      off = 5'd12;
    end else if (b <= 8'd190) begin
      off = 5'd14;
    end else begin
      off = 5'd16;
    end
    return off;
  endfunction

  // Calibrated code for a level in 0.01 mA; quo is lvl / 10
  function automatic logic [CODE_W-1:0] ma_code(input logic [LVL_W-1:0] lvl,
                                                input logic [QUO_W-1:0] quo);
    logic [LVL_W-1:0]  tens;
    logic [3:0]        rem;
    logic [QUO_W-1:0]  idx;
    logic [CODE_W-1:0] code;
    tens = {quo, 3'b000} + {2'b00, quo, 1'b0};
    rem  = 4'(lvl - tens);
    idx  = quo - IDX_BASE;
    if (lvl < MA_LOW) begin
      code = CAL_ROM[0];
    end else if (lvl > MA_HIGH) begin
      code = CAL_ROM[CAL_LAST];
    end else begin
      if (idx > CAL_LAST) begin
        idx = CAL_LAST;
      end
      code = CAL_ROM[idx] + {8'd0, frac_step(rem)};
    end
    return code;
  endfunction

endpackage

### rtl/core/acdc_if.sv
// ----------------------------------------------------------------------------
// acdc channel interfaces
// Valid/ready channels for commands, DAC code pairs and register writes.
// ----------------------------------------------------------------------------
interface acdc_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [acdc_pkg::CMD_W-1:0]     command_level;
  modport source (output valid, output command_level, input ready);
  modport sink   (input valid, input command_level, output ready);
endinterface

interface acdc_code_if;
  logic                           valid;
  logic                           ready;
  logic [acdc_pkg::CODE_W-1:0]    first_dac_code;
  logic [acdc_pkg::CODE_W-1:0]    second_dac_code;
  modport source (output valid, output first_dac_code, output second_dac_code,
                  input ready);
  modport sink   (input valid, input first_dac_code, input second_dac_code,
                  output ready);
endinterface

interface acdc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [acdc_pkg::CFG_IDX_W-1:0] index;
  logic [acdc_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/actuator_command_to_dac_codes_core.sv
// ----------------------------------------------------------------------------
// actuator_command_to_dac_codes_core
// Turns one actuator command into a pair of 12-bit DAC codes.
// ----------------------------------------------------------------------------
// Channels: cmd takes one command_level per beat (0.01 % opening or 0.01 Hz,
// values above 10000 saturate). code delivers first_dac_code and
// second_dac_code for each command, in order. cfg writes actuator_mode
// (index 0) and signal_kind (index 1); it is always ready and should be
// used only while no command is in flight.
// Throughput: one command per cycle while code.ready holds, set by a
// five-register pipeline (range select, divide by 25, level clamp, scale
// multiply, calibration ROM and output register), each stage holding one
// beat.
// Reset: rst clears all valid bits and sets both registers to 0 (single
// valve, current loop); no command is lost or produced by reset release.
// Stall: a stalled result holds in the output register; earlier stages
// keep filling bubbles, and cmd.ready drops only once every stage is full.
// ----------------------------------------------------------------------------
module actuator_command_to_dac_codes_core (
  input  logic         clk,
  input  logic         rst,
  acdc_cmd_if.sink     cmd,
  acdc_code_if.source  code,
  acdc_cfg_if.sink     cfg
);

  acdc_pkg::mode_t mode;
  logic            kind;

  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic v1, v2, v3, v4, v5;

  logic [acdc_pkg::CMD_W-1:0] cmd_sat;
  logic [acdc_pkg::NUM_W-1:0] c4, c8, c5;
  logic [acdc_pkg::NUM_W-1:0] num_next;
  acdc_pkg::ctl_t             ctl_next;

  logic [acdc_pkg::NUM_W-1:0] num1;
  acdc_pkg::ctl_t             ctl1;

  logic [acdc_pkg::NUM_W+17:0] div_prod;
  logic [acdc_pkg::Q_W-1:0]    q2;
  acdc_pkg::ctl_t              ctl2;

  logic [acdc_pkg::Q_W-1:0]   full_lvl, lvl_raw, lvl_clamped;
  logic [acdc_pkg::LVL_W-1:0] lvl1, lvl2;
  acdc_pkg::ctl_t             ctl3;

  logic [acdc_pkg::KMUL_W-1:0] kmul;
  logic [acdc_pkg::PROD_W-1:0] prod1, prod2;
  logic [acdc_pkg::QUO_W-1:0]  quo1, quo2;
  logic [acdc_pkg::CODE_W-1:0] vcode1, vcode2;
  logic [acdc_pkg::LVL_W-1:0]  lvl4a, lvl4b;
  acdc_pkg::ctl_t              ctl4;

  logic [acdc_pkg::CODE_W-1:0] ma1, ma2, ma2_sub;
  logic [4:0]                  off2;
  logic [acdc_pkg::CODE_W-1:0] first_next, second_next;
  logic [acdc_pkg::CODE_W-1:0] first_code, second_code;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= acdc_pkg::MODE_SINGLE;
      kind <= acdc_pkg::KIND_CURRENT;
    end else if (cfg.valid) begin
      case (cfg.index)
        acdc_pkg::REG_MODE: mode <= cfg.data;
        acdc_pkg::REG_KIND: kind <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Flow control: a stage loads when empty or when its successor loads
  assign rdy5      = !v5 || code.ready;
  assign rdy4      = !v4 || rdy5;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign cmd.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= cmd.valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
      if (rdy5) begin
        v5 <= v4;
      end
    end
  end

  // Stage 1: saturate, pick the numerator over 25 for each range
  always_comb begin
    cmd_sat  = (cmd.command_level > acdc_pkg::CMD_MAX) ? acdc_pkg::CMD_MAX
                                                       : cmd.command_level;
    c4       = {1'b0, cmd_sat, 2'b00};
    c8       = {cmd_sat, 3'b000};
    c5       = {1'b0, cmd_sat, 2'b00} + {3'b000, cmd_sat};
    num_next = c8;
    ctl_next = '0;
    ctl_next.current = (kind == acdc_pkg::KIND_CURRENT);
    case (mode)
      acdc_pkg::MODE_SINGLE: begin
        if (ctl_next.current) begin
          num_next          = c4;
          ctl_next.add_base = 1'b1;
        end else begin
          num_next = {1'b0, c5[acdc_pkg::NUM_W-1:1]};
        end
      end
      acdc_pkg::MODE_SPLIT: begin
        if (cmd_sat < acdc_pkg::CMD_HALF) begin
          num_next          = ctl_next.current ? c8 : c5;
          ctl_next.add_base = ctl_next.current;
          ctl_next.full2    = 1'b1;
        end else if (cmd_sat > acdc_pkg::CMD_HALF) begin
          num_next       = ctl_next.current ? (17'd90000 - c8) : (17'd50000 - c5);
          ctl_next.full1 = 1'b1;
        end else begin
          ctl_next.full1 = 1'b1;
          ctl_next.full2 = 1'b1;
        end
      end
      acdc_pkg::MODE_PUMP: begin
        num_next          = ctl_next.current ? c8 : c5;
        ctl_next.add_base = ctl_next.current;
        ctl_next.clamp    = 1'b1;
      end
      default: begin
        ctl_next.zero = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      num1 <= num_next;
      ctl1 <= ctl_next;
    end
  end

  // Stage 2: divide by 25
  assign div_prod = num1 * acdc_pkg::DIV25_K;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      q2   <= div_prod[acdc_pkg::DIV25_S +: acdc_pkg::Q_W];
      ctl2 <= ctl1;
    end
  end

  // Stage 3: offset, clamp, route to channels
  always_comb begin
    full_lvl    = ctl2.current ? acdc_pkg::FULL_MA : acdc_pkg::FULL_V;
    lvl_raw     = q2 + (ctl2.add_base ? acdc_pkg::BASE_MA : '0);
    lvl_clamped = (ctl2.clamp && (lvl_raw > full_lvl)) ? full_lvl : lvl_raw;
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      lvl1 <= ctl2.full1 ? full_lvl[acdc_pkg::LVL_W-1:0]
                         : lvl_clamped[acdc_pkg::LVL_W-1:0];
      lvl2 <= ctl2.full2 ? full_lvl[acdc_pkg::LVL_W-1:0]
                         : lvl_clamped[acdc_pkg::LVL_W-1:0];
      ctl3 <= ctl2;
    end
  end

  // Stage 4: divide by 10 (current) or scale to code (voltage)
  assign kmul  = ctl3.current ? acdc_pkg::DIV10_K : acdc_pkg::VOLT_K;
  assign prod1 = lvl1 * kmul;
  assign prod2 = lvl2 * kmul;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      quo1   <= prod1[acdc_pkg::DIV10_S +: acdc_pkg::QUO_W];
      quo2   <= prod2[acdc_pkg::DIV10_S +: acdc_pkg::QUO_W];
      vcode1 <= prod1[acdc_pkg::VOLT_S +: acdc_pkg::CODE_W];
      vcode2 <= prod2[acdc_pkg::VOLT_S +: acdc_pkg::CODE_W];
      lvl4a  <= lvl1;
      lvl4b  <= lvl2;
      ctl4   <= ctl3;
    end
  end

  // Stage 5: calibration lookup, band offset, saturation
  always_comb begin
    ma1     = acdc_pkg::ma_code(lvl4a, quo1);
    ma2     = acdc_pkg::ma_code(lvl4b, quo2);
    off2    = acdc_pkg::band_offset(quo2);
    ma2_sub = (ma2 >= {7'd0, off2}) ? (ma2 - {7'd0, off2}) : '0;
    if (ctl4.zero) begin
      first_next  = '0;
      second_next = '0;
    end else if (ctl4.current) begin
      first_next  = ma1;
      second_next = ma2_sub;
    end else begin
      first_next  = (vcode1 > acdc_pkg::V_CODE_MAX) ? acdc_pkg::V_CODE_MAX : vcode1;
      second_next = (vcode2 > acdc_pkg::V_CODE_MAX) ? acdc_pkg::V_CODE_MAX : vcode2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      first_code  <= first_next;
      second_code <= second_next;
    end
  end

  assign code.valid           = v5;
  assign code.first_dac_code  = first_code;
  assign code.second_dac_code = second_code;

`ifndef NO_ASSERTIONS
  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    (v1 && !rdy2) |=> (v1 && $stable(num1)))
    else $error("stage 1 beat lost or changed while stalled");

  a_stage4_moves: assert property (@(posedge clk) disable iff (rst)
    (v4 && rdy5) |=> code.valid)
    else $error("stage 4 beat did not reach the output register");

  a_unused_mode_zero: assert property (@(posedge clk) disable iff (rst)
    (v4 && rdy5 && ctl4.zero) |=>
      (code.first_dac_code == '0 && code.second_dac_code == '0))
    else $error("unused mode gave nonzero codes");

  a_current_floor: assert property (@(posedge clk) disable iff (rst)
    (v4 && rdy5 && ctl4.current && !ctl4.zero) |=>
      (code.first_dac_code >= acdc_pkg::CAL_ROM[0]))
    else $error("current code below calibration floor");
`endif

endmodule
